/* rtl/core/pct_pkg.sv */
// Shared types, constants and helpers for the polar cosine taper pipeline.
// No dependencies; every other rtl/core file but pct_checker.sv imports this package.
`default_nettype none
package pct_pkg;

    // angle constants, 1/256 degree
    localparam int QUARTER_TURN = 23040;
    localparam int HALF_TURN    = 46080;
    localparam logic signed [15:0] LAT_MAX = 16'sd23040;
    localparam logic signed [15:0] LAT_MIN = -16'sd23040;

    // cutoff latitude after reset: 60 degrees
    localparam logic [14:0] CUTOFF_RESET = 15'd15360;

    // odd sine polynomial, Q28
    localparam logic signed [31:0] COEF1 = 32'sd843314857;
    localparam logic signed [31:0] COEF3 = 32'sd1387197337;
    localparam logic signed [31:0] COEF5 = 32'sd684554447;
    localparam logic signed [31:0] COEF7 = 32'sd160863847;
    localparam logic signed [31:0] COEF9 = 32'sd22050869;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [22:0] MAG_MAX = 23'd8388607;
    localparam logic signed [25:0] OUT_MAX = 26'sd8388607;
    localparam logic signed [25:0] OUT_MIN = -26'sd8388608;

    // pipeline depths
    localparam int DIV_STAGES  = 16;
    localparam int WGT_STAGES  = 8;
    localparam int SQRT_STAGES = 24;
    localparam int PAY_DLY     = DIV_STAGES + WGT_STAGES;

    // phase word leaving the divider
    typedef struct packed {
        logic        vld;
        logic        taper;
        logic [15:0] p;
    } t_phase;

    // one point's vectors, axis 0..2 = x..z
    typedef struct packed {
        logic [2:0][23:0] resid;
        logic [2:0][23:0] model;
    } t_pay;

    // one Horner step: c - floor(pv*y/2^16)
    function automatic logic signed [31:0] horner(input logic signed [31:0] c,
                                                  input logic signed [31:0] pv,
                                                  input logic [14:0] y);
        logic signed [47:0] prod;
        prod = 48'(pv) * $signed({33'd0, y});
        return c - prod[47:16];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/polar_cosine_taper.sv */
// Accepts one word per cycle while the output word is not held.
// Depth comes mostly from the 16-stage phase divider and 24-stage square root.
// A stalled output word freezes the whole pipeline; nothing is dropped.
// Synchronous active-low reset clears all valid bits and loads cutoff 60 deg.
// Depends on pct_pkg, pct_divider, pct_weight, pct_isqrt.
`default_nettype none
module polar_cosine_taper (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // point input
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  signed [15:0]  i_latitude,
    input  wire  signed [23:0]  i_resid_x,
    input  wire  signed [23:0]  i_resid_y,
    input  wire  signed [23:0]  i_resid_z,
    input  wire  signed [23:0]  i_model_x,
    input  wire  signed [23:0]  i_model_y,
    input  wire  signed [23:0]  i_model_z,
    // result output
    output logic                o_valid,
    input  wire                 i_stall,
    output logic signed [23:0]  o_out_x,
    output logic signed [23:0]  o_out_y,
    output logic signed [23:0]  o_out_z,
    output logic        [22:0]  o_magnitude,
    // cutoff latitude register
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire         [14:0]  i_cfg_data
);
    import pct_pkg::*;

    logic en;
    logic r_out_vld;

    // whole pipe moves unless the output word is held
    assign en          = ~r_out_vld | ~i_stall;
    assign o_stall     = ~en;
    assign o_cfg_ready = 1'b1;

    // cutoff register
    logic [14:0] r_cutoff;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cutoff <= i_cfg_data;
        end
    end

    // front: clamp latitude, find zone and distance to nearer pole
    logic signed [15:0] lat_c;
    logic signed [17:0] t_s;
    logic signed [17:0] t0_s;
    logic signed [17:0] d_s;
    logic               north;
    logic               south;
    logic               taper;
    always_comb begin
        if (i_latitude > LAT_MAX) begin
            lat_c = LAT_MAX;
        end else if (i_latitude < LAT_MIN) begin
            lat_c = LAT_MIN;
        end else begin
            lat_c = i_latitude;
        end
        t_s   = 18'(QUARTER_TURN) - 18'(lat_c);
        t0_s  = 18'(QUARTER_TURN) - $signed({3'b000, r_cutoff});
        north = t_s < t0_s;
        south = t_s > (18'(HALF_TURN) - t0_s);
        taper = (t0_s > 18'sd0) && (north || south);
        d_s   = north ? t_s : 18'(HALF_TURN) - t_s;
    end

    t_pay in_pay;
    assign in_pay.resid = {i_resid_z, i_resid_y, i_resid_x};
    assign in_pay.model = {i_model_z, i_model_y, i_model_x};

    logic        r0_vld;
    logic        r0_taper;
    logic [14:0] r0_d;
    logic [14:0] r0_t0;
    t_pay        r0_pay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_taper <= taper;
            r0_d     <= d_s[14:0];
            r0_t0    <= t0_s[14:0];
            r0_pay   <= in_pay;
        end
    end

    // weight path
    t_phase      phase;
    logic        w_vld;
    logic [16:0] w2;

    pct_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r0_vld),
        .i_taper (r0_taper),
        .i_d     (r0_d),
        .i_t0    (r0_t0),
        .o_phase (phase)
    );

    pct_weight u_wgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_phase (phase),
        .o_vld   (w_vld),
        .o_w2    (w2)
    );

    // vectors wait alongside the weight path
    t_pay [PAY_DLY-1:0] r_pd;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pd <= {r_pd[PAY_DLY-2:0], r0_pay};
        end
    end

    // H1: residual magnitude and sign
    logic             r1_vld;
    logic [2:0][23:0] r1_ar;
    logic [2:0]       r1_neg;
    logic [2:0][23:0] r1_m;
    logic [16:0]      r1_w2;
    logic [2:0][23:0] n1_ar;
    logic [2:0]       n1_neg;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_neg[k] = r_pd[PAY_DLY-1].resid[k][23];
            n1_ar[k]  = n1_neg[k] ? 24'(~r_pd[PAY_DLY-1].resid[k] + 24'd1)
                                  : r_pd[PAY_DLY-1].resid[k];
        end
    end

    // H2: rounded tapered magnitude
    logic             r2_vld;
    logic [2:0][23:0] r2_tap;
    logic [2:0]       r2_neg;
    logic [2:0][23:0] r2_m;
    logic [2:0][23:0] n2_tap;
    always_comb begin
        logic [40:0] prod;
        for (int k = 0; k < 3; k++) begin
            prod      = 41'(r1_ar[k] * r1_w2) + 41'd32768;
            n2_tap[k] = prod[39:16];
        end
    end

    // H3: add to model and saturate
    logic             r3_vld;
    logic [2:0][23:0] r3_o;
    logic [2:0][23:0] n3_o;
    always_comb begin
        logic signed [25:0] sum;
        for (int k = 0; k < 3; k++) begin
            if (r2_neg[k]) begin
                sum = 26'($signed(r2_m[k])) - $signed({2'b00, r2_tap[k]});
            end else begin
                sum = 26'($signed(r2_m[k])) + $signed({2'b00, r2_tap[k]});
            end
            if (sum > OUT_MAX) begin
                n3_o[k] = OUT_MAX[23:0];
            end else if (sum < OUT_MIN) begin
                n3_o[k] = OUT_MIN[23:0];
            end else begin
                n3_o[k] = sum[23:0];
            end
        end
    end

    // H4: squares
    logic             r4_vld;
    logic [2:0][23:0] r4_o;
    logic [2:0][46:0] r4_sq;
    logic [2:0][46:0] n4_sq;
    always_comb begin
        logic signed [47:0] sq;
        for (int k = 0; k < 3; k++) begin
            sq       = 48'($signed(r3_o[k])) * 48'($signed(r3_o[k]));
            n4_sq[k] = sq[46:0];
        end
    end

    // H5: sum of squares
    logic             r5_vld;
    logic [2:0][23:0] r5_o;
    logic [47:0]      r5_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= w_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ar  <= n1_ar;
            r1_neg <= n1_neg;
            r1_m   <= r_pd[PAY_DLY-1].model;
            r1_w2  <= w2;
            r2_tap <= n2_tap;
            r2_neg <= r1_neg;
            r2_m   <= r1_m;
            r3_o   <= n3_o;
            r4_o   <= r3_o;
            r4_sq  <= n4_sq;
            r5_o   <= r4_o;
            r5_sum <= 48'(r4_sq[0]) + 48'(r4_sq[1]) + 48'(r4_sq[2]);
        end
    end

    // magnitude
    logic        q_vld;
    logic [23:0] q_root;
    logic [25:0] q_rem;

    pct_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r5_vld),
        .i_n     (r5_sum),
        .o_vld   (q_vld),
        .o_root  (q_root),
        .o_rem   (q_rem)
    );

    // corrected vector waits for the root
    logic [SQRT_STAGES-1:0][2:0][23:0] r_od;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_od <= {r_od[SQRT_STAGES-2:0], r5_o};
        end
    end

    // output: round to nearest, saturate
    logic [24:0] mag_r;
    logic [22:0] n_mag;
    always_comb begin
        mag_r = (q_rem > {2'b00, q_root}) ? 25'(q_root) + 25'd1 : 25'(q_root);
        n_mag = (mag_r > 25'(MAG_MAX)) ? MAG_MAX : mag_r[22:0];
    end

    logic [2:0][23:0] r_out;
    logic [22:0]      r_mag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= q_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= r_od[SQRT_STAGES-1];
            r_mag <= n_mag;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_x     = $signed(r_out[0]);
    assign o_out_y     = $signed(r_out[1]);
    assign o_out_z     = $signed(r_out[2]);
    assign o_magnitude = r_mag;

endmodule
`default_nettype wire

/* rtl/core/pct_divider.sv */
// Restoring divider, one quotient bit per stage: p = floor(d*2^16/t0), d < t0.
// Depends on pct_pkg.
`default_nettype none
module pct_divider (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  wire                 i_taper,
    input  wire  [14:0]         i_d,
    input  wire  [14:0]         i_t0,
    output pct_pkg::t_phase     o_phase
);
    import pct_pkg::*;

    logic [DIV_STAGES-1:0]        r_vld;
    logic [DIV_STAGES-1:0]        r_taper;
    logic [DIV_STAGES-1:0][14:0]  r_rem;
    logic [DIV_STAGES-1:0][14:0]  r_t0;
    logic [DIV_STAGES-1:0][15:0]  r_q;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [14:0] rem_in;
        logic [14:0] t0_in;
        logic [15:0] q_in;
        logic        vld_in;
        logic        taper_in;
        logic [15:0] two;
        logic        ge;
        logic [14:0] n_rem;

        if (k == 0) begin : g_first
            assign rem_in   = i_d;
            assign t0_in    = i_t0;
            assign q_in     = 16'd0;
            assign vld_in   = i_vld;
            assign taper_in = i_taper;
        end else begin : g_next
            assign rem_in   = r_rem[k-1];
            assign t0_in    = r_t0[k-1];
            assign q_in     = r_q[k-1];
            assign vld_in   = r_vld[k-1];
            assign taper_in = r_taper[k-1];
        end

        // shift remainder, subtract divisor when it fits
        assign two   = {rem_in, 1'b0};
        assign ge    = two >= {1'b0, t0_in};
        assign n_rem = ge ? 15'(two - {1'b0, t0_in}) : two[14:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]   <= n_rem;
                r_t0[k]    <= t0_in;
                r_q[k]     <= {q_in[14:0], ge};
                r_taper[k] <= taper_in;
            end
        end
    end

    assign o_phase.vld   = r_vld[DIV_STAGES-1];
    assign o_phase.taper = r_taper[DIV_STAGES-1];
    assign o_phase.p     = r_q[DIV_STAGES-1];

endmodule
`default_nettype wire

/* rtl/core/pct_weight.sv */
// Raised-cosine weight squared from the Q16 phase: sine polynomial by Horner,
// one multiply per stage, then weight clamp and square. Depends on pct_pkg.
`default_nettype none
module pct_weight (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  pct_pkg::t_phase  i_phase,
    output logic             o_vld,
    output logic [16:0]      o_w2
);
    import pct_pkg::*;

    logic [WGT_STAGES-1:0] r_vld;
    logic [WGT_STAGES-1:0] r_taper;
    logic [WGT_STAGES-1:0] r_neg;

    logic [15:0]        r_ax_a, r_ax_b, r_ax_c, r_ax_d, r_ax_e;
    logic [14:0]        r_y_a, r_y_b, r_y_c, r_y_d;
    logic signed [31:0] r_p7, r_p5, r_p3, r_p1;
    logic signed [20:0] r_s;
    logic [16:0]        r_w;
    logic [16:0]        r_w2;

    // stage A: |x| and y = x*x/2^16
    logic        neg;
    logic [15:0] ax;
    logic [31:0] ax_sq;
    assign neg   = ~i_phase.p[15];
    assign ax    = neg ? 16'(17'd32768 - {1'b0, i_phase.p})
                       : 16'(i_phase.p - 16'd32768);
    assign ax_sq = ax * ax;

    // stage F: s = P1*|x|/2^28
    logic signed [48:0] s_prod;
    assign s_prod = 49'(r_p1) * $signed({33'd0, r_ax_e});

    // stage G: W = (1 +/- s)/2 clamped to 0..1
    logic signed [22:0] w_wide;
    logic [21:0]        w_half;
    logic [16:0]        n_w;
    always_comb begin
        if (r_neg[5]) begin
            w_wide = 23'sd65536 - 23'(r_s);
        end else begin
            w_wide = 23'sd65536 + 23'(r_s);
        end
        if (w_wide[22]) begin
            w_half = 22'd0;
        end else begin
            w_half = w_wide[22:1];
        end
        if (w_half > 22'(ONE_Q16)) begin
            n_w = ONE_Q16;
        end else begin
            n_w = w_half[16:0];
        end
    end

    // stage H: square, or unit weight outside the taper zones
    logic [33:0] w_sq;
    assign w_sq = r_w * r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[WGT_STAGES-2:0], i_phase.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_taper <= {r_taper[WGT_STAGES-2:0], i_phase.taper};
            r_neg   <= {r_neg[WGT_STAGES-2:0], neg};
            r_ax_a  <= ax;
            r_y_a   <= ax_sq[30:16];
            r_ax_b  <= r_ax_a;
            r_y_b   <= r_y_a;
            r_p7    <= horner(COEF7, COEF9, r_y_a);
            r_ax_c  <= r_ax_b;
            r_y_c   <= r_y_b;
            r_p5    <= horner(COEF5, r_p7, r_y_b);
            r_ax_d  <= r_ax_c;
            r_y_d   <= r_y_c;
            r_p3    <= horner(COEF3, r_p5, r_y_c);
            r_ax_e  <= r_ax_d;
            r_p1    <= horner(COEF1, r_p3, r_y_d);
            r_s     <= s_prod[48:28];
            r_w     <= n_w;
            r_w2    <= r_taper[6] ? w_sq[32:16] : ONE_Q16;
        end
    end

    assign o_vld = r_vld[WGT_STAGES-1];
    assign o_w2  = r_w2;

endmodule
`default_nettype wire

/* rtl/core/pct_isqrt.sv */
// Digit-by-digit integer square root of a 48-bit sum, one root bit per stage.
// Gives floor root and remainder. Depends on pct_pkg.
`default_nettype none
module pct_isqrt (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire          i_vld,
    input  wire  [47:0]  i_n,
    output logic         o_vld,
    output logic [23:0]  o_root,
    output logic [25:0]  o_rem
);
    import pct_pkg::*;

    logic [SQRT_STAGES-1:0]        r_vld;
    logic [SQRT_STAGES-1:0][47:0]  r_n;
    logic [SQRT_STAGES-1:0][23:0]  r_root;
    logic [SQRT_STAGES-1:0][25:0]  r_rem;

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [47:0] n_in;
        logic [23:0] root_in;
        logic [25:0] rem_in;
        logic        vld_in;
        logic [27:0] cur;
        logic [27:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign n_in    = i_n;
            assign root_in = 24'd0;
            assign rem_in  = 26'd0;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign n_in    = r_n[k-1];
            assign root_in = r_root[k-1];
            assign rem_in  = r_rem[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // bring down the next bit pair, try root*4+1
        assign cur   = {rem_in, n_in[47-2*k -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]    <= n_in;
                r_root[k] <= {root_in[22:0], ge};
                r_rem[k]  <= ge ? 26'(cur - trial) : cur[25:0];
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_root = r_root[SQRT_STAGES-1];
    assign o_rem  = r_rem[SQRT_STAGES-1];

endmodule
`default_nettype wire

/* rtl/core/pct_checker.sv */
// Port-level checks for polar_cosine_taper, attached by bind below.
// Sees only top-level ports; no package needed.
`default_nettype none
module pct_port_checks (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_stall,
    input wire                 o_valid,
    input wire                 i_stall,
    input wire  signed [23:0]  o_out_x,
    input wire         [22:0]  o_magnitude
);

    // a held output word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    // input backs up only behind a held output word
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with free output");

    // reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word after reset");

    // norm is never below a non-negative x component
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_x[23] |-> o_magnitude >= o_out_x[22:0])
        else $error("magnitude below x component");

endmodule

bind polar_cosine_taper pct_port_checks u_pct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_x     (o_out_x),
    .o_magnitude (o_magnitude)
);
`default_nettype wire

/* sim/pct_checker.sv */
// Checker for polar_cosine_taper: watches point, result and cutoff words,
// predicts each result from its own fixed-point model and compares.
// Depends on pct_pkg for the angle and polynomial constants and cutoff reset value.
`timescale 1ns / 100ps
module pct_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire               i_stall_in,
    input  wire signed [15:0] i_latitude,
    input  wire signed [23:0] i_resid_x,
    input  wire signed [23:0] i_resid_y,
    input  wire signed [23:0] i_resid_z,
    input  wire signed [23:0] i_model_x,
    input  wire signed [23:0] i_model_y,
    input  wire signed [23:0] i_model_z,
    input  wire               i_out_valid,
    input  wire               i_out_stall,
    input  wire signed [23:0] i_out_x,
    input  wire signed [23:0] i_out_y,
    input  wire signed [23:0] i_out_z,
    input  wire        [22:0] i_magnitude,
    input  wire               i_cfg_valid,
    input  wire               i_cfg_ready,
    input  wire        [14:0] i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    import pct_pkg::*;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic        [22:0] mag;
    } t_corrected;

    t_corrected corrected_q[$];
    logic [14:0] cutoff;

    assign o_pending = corrected_q.size();

    // squared taper weight, Q16, 0..65536
    function automatic longint weight_sq(longint lat, longint t0);
        longint t, d, p, x, ax, y, pp, s, w;
        if (lat > QUARTER_TURN) lat = QUARTER_TURN;
        if (lat < -QUARTER_TURN) lat = -QUARTER_TURN;
        t = QUARTER_TURN - lat;
        if (t0 <= 0) return 65536;
        if (t < t0) d = t;
        else if (t > HALF_TURN - t0) d = HALF_TURN - t;
        else return 65536;
        if (d < 0) d = 0;
        p = (d * 65536) / t0;
        x = p - 32768;
        ax = (x < 0) ? -x : x;
        y = (ax * ax) >>> 16;
        pp = COEF9;
        pp = COEF7 - ((pp * y) >>> 16);
        pp = COEF5 - ((pp * y) >>> 16);
        pp = COEF3 - ((pp * y) >>> 16);
        pp = COEF1 - ((pp * y) >>> 16);
        s = (pp * ax) >>> 28;
        w = (x < 0) ? 65536 - s : 65536 + s;
        if (w < 0) w = 0;
        w = w >>> 1;
        if (w > 65536) w = 65536;
        return (w * w) >>> 16;
    endfunction

    // model + rounded tapered residual, saturated to 24 bits
    function automatic longint taper_axis(longint r, longint m, longint w2);
        longint ar, tap, v;
        ar = (r < 0) ? -r : r;
        tap = (ar * w2 + 32768) >>> 16;
        if (r < 0) tap = -tap;
        v = m + tap;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v;
    endfunction

    // integer square root rounded to nearest
    function automatic longint root_round(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (n > r) r++;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        longint w2, ox, oy, oz, mag;
        t_corrected c;
        if (!i_rst_n) begin
            cutoff <= CUTOFF_RESET;
            corrected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) cutoff <= i_cfg_data;
            // prediction for each accepted point word
            if (i_valid && !i_stall_in) begin
                w2 = weight_sq(i_latitude, QUARTER_TURN - longint'(cutoff));
                ox = taper_axis(i_resid_x, i_model_x, w2);
                oy = taper_axis(i_resid_y, i_model_y, w2);
                oz = taper_axis(i_resid_z, i_model_z, w2);
                mag = root_round(ox * ox + oy * oy + oz * oz);
                if (mag > 8388607) mag = 8388607;
                corrected_q.push_back({24'(ox), 24'(oy), 24'(oz), 23'(mag)});
            end
            // compare each accepted result word
            if (i_out_valid && !i_out_stall) begin
                if (corrected_q.size() == 0) begin
                    report("unexpected result word", 0, 0);
                end else begin
                    c = corrected_q.pop_front();
                    if (i_out_x !== c.x) report("out_x", i_out_x, c.x);
                    if (i_out_y !== c.y) report("out_y", i_out_y, c.y);
                    if (i_out_z !== c.z) report("out_z", i_out_z, c.z);
                    if (i_magnitude !== c.mag) report("magnitude", i_magnitude, c.mag);
                end
            end
        end
    end

    initial o_errors = 0;
endmodule

/* sim/tb_top.sv */
// Testbench top for polar_cosine_taper: reset, cutoff phases, directed and
// random points with bursty input and random output stall; verdict from pct_checker.
`timescale 1ns / 100ps
module tb_top;
    import pct_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic signed [15:0] lat = 0;
    logic signed [23:0] rx = 0, ry = 0, rz = 0, mx = 0, my = 0, mz = 0;
    logic o_valid;
    logic i_stall = 0;
    logic signed [23:0] ox, oy, oz;
    logic [22:0] omag;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [14:0] cfg_data = 0;
    int errors, pending;
    bit stall_en = 1;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    polar_cosine_taper dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_latitude(lat),
        .i_resid_x(rx), .i_resid_y(ry), .i_resid_z(rz),
        .i_model_x(mx), .i_model_y(my), .i_model_z(mz),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_x(ox), .o_out_y(oy), .o_out_z(oz), .o_magnitude(omag),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    pct_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_latitude(lat),
        .i_resid_x(rx), .i_resid_y(ry), .i_resid_z(rz),
        .i_model_x(mx), .i_model_y(my), .i_model_z(mz),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_x(ox), .i_out_y(oy), .i_out_z(oz), .i_magnitude(omag),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: stretches of random stall, stretches of none
    always @(posedge i_clk) begin
        int phase;
        phase = ($time / 2000) % 3;
        if (!stall_en || phase == 2) i_stall <= 0;
        else if (phase == 0) i_stall <= ($urandom_range(0, 3) == 0);
        else i_stall <= ($urandom_range(0, 1) == 0);
    end

    function automatic logic [23:0] pick_field();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    // one point word; valid held until accepted
    task automatic send_point(input logic signed [15:0] la, input logic [23:0] a,
                              input logic [23:0] b, input logic [23:0] c,
                              input logic [23:0] d, input logic [23:0] e,
                              input logic [23:0] f);
        i_valid <= 1;
        lat <= la;
        rx <= a; ry <= b; rz <= c;
        mx <= d; my <= e; mz <= f;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            i_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic random_latitude(output logic signed [15:0] la, input logic [14:0] cut);
        int t0;
        t0 = QUARTER_TURN - cut;
        case ($urandom_range(0, 4))
            0: la = 16'($urandom);
            1: la = (QUARTER_TURN > cut) ?
                    16'(cut + $urandom_range(0, t0)) : 16'($urandom);
            2: la = (QUARTER_TURN > cut) ?
                    -16'(cut + $urandom_range(0, t0)) : 16'($urandom);
            default: la = 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
    endtask

    // drain, then write cutoff while idle
    task automatic set_cutoff(input logic [14:0] v);
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 0;
    endtask

    initial begin
        logic [14:0] cutoffs[6];
        logic [14:0] cut;
        logic signed [15:0] la;
        int left, burst;
        cutoffs = '{15'd15360, 15'd0, 15'd22784, 15'd23040, 15'd32767, 15'd11520};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes of the fields and latitudes at reset cutoff
        send_point(16'sh7FFF, 24'h7FFFFF, 24'h800000, 24'h0, 24'h7FFFFF, 24'h800000, 24'h0);
        send_point(16'sh8000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 24'h0, 24'h0);
        send_point(16'sd23040, 24'h123456, 24'hFEDCBA, 24'h1, 24'h2, 24'h3, 24'h4);
        send_point(-16'sd23040, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                   24'h800000, 24'h800000);
        send_point(16'sd15360, 24'd1000, 24'd2000, 24'd3000, 24'd0, 24'd0, 24'd0);
        send_point(-16'sd15360, 24'd1000, 24'd2000, 24'd3000, 24'd5, 24'd5, 24'd5);
        send_point(16'sd15361, 24'hFFFFFF, 24'd1, 24'd32768, 24'd0, 24'd0, 24'd0);
        send_point(16'sd19200, 24'd65536, 24'd65535, 24'hFF0000, 24'd7, 24'd0, 24'd0);
        send_point(-16'sd19200, 24'd65536, 24'd65535, 24'hFF0000, 24'd7, 24'd0, 24'd0);
        send_point(16'sd0, 24'h555555, 24'hAAAAAA, 24'h0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_point(16'sd23039, 24'h7FFFFF, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
        send_point(16'sh5A01, 24'd300, 24'd300, 24'd300, 24'd1, 24'd1, 24'd1);
        send_point(16'shA5FF, 24'd300, 24'd300, 24'd300, 24'd1, 24'd1, 24'd1);

        // random phases across cutoff settings
        for (int ph = 0; ph < 6; ph++) begin
            cut = cutoffs[ph];
            set_cutoff(cut);
            if (cut == 0) send_point(16'sd0, 24'd5000, 24'd5000, 24'd5000, 24'd0, 24'd0, 24'd0);
            stall_en = (ph != 3);
            left = 230;
            while (left > 0) begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst && left > 0; k++) begin
                    random_latitude(la, cut);
                    send_point(la, pick_field(), pick_field(), pick_field(),
                               pick_field(), pick_field(), pick_field());
                    left--;
                end
                idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
            end
        end

        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* files.f */
rtl/core/pct_pkg.sv
rtl/core/pct_divider.sv
rtl/core/pct_weight.sv
rtl/core/pct_isqrt.sv
rtl/core/polar_cosine_taper.sv
rtl/core/pct_checker.sv
sim/pct_checker.sv
sim/tb_top.sv
